@@ src/windowed_record_pair_matcher_assert.svh @@
// Assertion macros shared by the windowed record pair matcher RTL.
`ifndef WINDOWED_RECORD_PAIR_MATCHER_ASSERT_SVH
`define WINDOWED_RECORD_PAIR_MATCHER_ASSERT_SVH

`ifndef SYNTHESIS

// Checks that a condition holds in the same cycle.
`define WRPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition holds in the cycle after the trigger.
`define WRPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WRPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define WRPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ src/wrpm_pkg.sv @@
// Package with widths, register indexes and control types of the record pair matcher.
`default_nettype none

package wrpm_pkg;

    localparam int MAX_RECORDS_DEF = 64;
    localparam int NUM_COV_DEF     = 4;
    localparam int MAX_COV         = 4;

    localparam int DATE_W     = 16;
    localparam int KEY_W      = 32;
    localparam int COV_W      = 32;
    localparam int IDX_OUT_W  = 6;
    localparam int COVCNT_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [DATE_W-1:0]   WINDOW_RESET = 16'd15;
    localparam logic [COVCNT_W-1:0] COVCNT_RESET = 3'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DATE_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COV_COUNT   = 2'd1;

    typedef struct packed {
        logic load;
        logic clear;
        logic scan_rd;
        logic finish;
        logic reject;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic full;
        logic scan_end;
    } t_status;

endpackage

`default_nettype wire

@@ src/wrpm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module wrpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/wrpm_ctrl.sv @@
// Controller state machine sequencing the scan of stored records for one item.
`default_nettype none

module wrpm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_mode,
    input  wire wrpm_pkg::t_status i_status,
    output wrpm_pkg::t_cmd         o_cmd,
    output logic                   o_busy
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_mode) begin
                        o_cmd.clear = 1'b1;
                    end else if (i_status.full) begin
                        o_cmd.reject = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = i_status.count_zero ? S_FINISH : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_status.scan_end) begin
                    n_state = S_DRAIN;
                end
            end
            // The last read returns here and is compared before the final result.
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

@@ src/wrpm_dp.sv @@
// Datapath: record table, configuration, per-entry comparison and result registers.
`default_nettype none

module wrpm_dp #(
    parameter int MAX_RECORDS    = wrpm_pkg::MAX_RECORDS_DEF,
    parameter int NUM_COVARIATES = wrpm_pkg::NUM_COV_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [wrpm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [wrpm_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  wire logic [wrpm_pkg::DATE_W-1:0]        i_record_date,
    input  wire logic [wrpm_pkg::KEY_W-1:0]         i_agent_key,
    input  wire logic [wrpm_pkg::KEY_W-1:0]         i_event_key,
    input  wire logic [wrpm_pkg::COV_W-1:0]         i_cov_a,
    input  wire logic [wrpm_pkg::COV_W-1:0]         i_cov_b,
    input  wire logic [wrpm_pkg::COV_W-1:0]         i_cov_c,
    input  wire logic [wrpm_pkg::COV_W-1:0]         i_cov_d,
    input  wire wrpm_pkg::t_cmd                     i_cmd,
    output wrpm_pkg::t_status                       o_status,
    output logic                                    o_result_valid,
    output logic [wrpm_pkg::IDX_OUT_W-1:0]          o_new_index,
    output logic [wrpm_pkg::IDX_OUT_W-1:0]          o_partner_index,
    output logic                                    o_match_found,
    output logic                                    o_table_full,
    output logic                                    o_last
);

    localparam int IDX_W   = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CNT_W   = $clog2(MAX_RECORDS + 1);
    localparam int DATE_W  = wrpm_pkg::DATE_W;
    localparam int KEY_W   = wrpm_pkg::KEY_W;
    localparam int COV_W   = wrpm_pkg::COV_W;
    localparam int AGENT_LO = DATE_W;
    localparam int EVENT_LO = DATE_W + KEY_W;
    localparam int COV_LO   = DATE_W + 2 * KEY_W;
    localparam int REC_W    = COV_LO + NUM_COVARIATES * COV_W;

    logic [DATE_W-1:0]             r_window;
    logic [wrpm_pkg::COVCNT_W-1:0] r_cov_count;

    logic [REC_W-1:0] r_rec;
    logic [REC_W-1:0] n_rec;
    logic [REC_W-1:0] rd_data;
    logic [COV_W-1:0] cov_in [wrpm_pkg::MAX_COV];

    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_ptr;
    logic             r_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx;
    logic             r_pend_vld;
    logic [IDX_W-1:0] r_pend_idx;

    logic                            r_out_vld;
    logic [wrpm_pkg::IDX_OUT_W-1:0]  r_out_new;
    logic [wrpm_pkg::IDX_OUT_W-1:0]  r_out_partner;
    logic                            r_out_found;
    logic                            r_out_full;
    logic                            r_out_last;

    logic [DATE_W-1:0] sd;
    logic [DATE_W-1:0] diff;
    logic              ids_ok;
    logic              cov_ok;
    logic              hit;

    assign cov_in[0] = i_cov_a;
    assign cov_in[1] = i_cov_b;
    assign cov_in[2] = i_cov_c;
    assign cov_in[3] = i_cov_d;

    always_comb begin
        n_rec = '0;
        n_rec[DATE_W-1:0]              = i_record_date;
        n_rec[AGENT_LO +: KEY_W]       = i_agent_key;
        n_rec[EVENT_LO +: KEY_W]       = i_event_key;
        for (int k = 0; k < NUM_COVARIATES; k++) begin
            n_rec[COV_LO + k * COV_W +: COV_W] = cov_in[k];
        end
    end

    wrpm_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_RECORDS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.finish),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (r_rec),
        .i_re    (i_cmd.scan_rd),
        .i_raddr (r_ptr),
        .o_rdata (rd_data)
    );

    // Compare the entry read in the previous cycle with the held item.
    always_comb begin
        sd     = rd_data[DATE_W-1:0];
        diff   = (r_rec[DATE_W-1:0] >= sd) ? (r_rec[DATE_W-1:0] - sd)
                                           : (sd - r_rec[DATE_W-1:0]);
        ids_ok = (rd_data[AGENT_LO +: KEY_W] != r_rec[AGENT_LO +: KEY_W]) &&
                 (rd_data[EVENT_LO +: KEY_W] != r_rec[EVENT_LO +: KEY_W]);
        cov_ok = 1'b1;
        for (int k = 0; k < NUM_COVARIATES; k++) begin
            if ((wrpm_pkg::COVCNT_W'(k) < r_cov_count) &&
                (rd_data[COV_LO + k * COV_W +: COV_W] !=
                 r_rec[COV_LO + k * COV_W +: COV_W])) begin
                cov_ok = 1'b0;
            end
        end
        hit = r_cmp_vld && ids_ok && (diff <= r_window) && cov_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= wrpm_pkg::WINDOW_RESET;
            r_cov_count <= wrpm_pkg::COVCNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wrpm_pkg::CFG_DATE_WINDOW: r_window    <= i_cfg_wdata[DATE_W-1:0];
                wrpm_pkg::CFG_COV_COUNT:   r_cov_count <= i_cfg_wdata[wrpm_pkg::COVCNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rec <= n_rec;
        end
        if (i_cmd.load) begin
            r_ptr <= '0;
        end else if (i_cmd.scan_rd) begin
            r_ptr <= r_ptr + IDX_W'(1);
        end
        r_cmp_idx <= r_ptr;
        if (hit) begin
            r_pend_idx <= r_cmp_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_cmp_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_rd;
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.finish) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.load) begin
                r_pend_vld <= 1'b0;
            end else if (hit) begin
                r_pend_vld <= 1'b1;
            end
        end
    end

    // One match is held back so that the final one of an item can carry last.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= (hit && r_pend_vld) || i_cmd.finish || i_cmd.reject;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.reject) begin
            r_out_new     <= '0;
            r_out_partner <= '0;
            r_out_found   <= 1'b0;
            r_out_full    <= 1'b1;
            r_out_last    <= 1'b1;
        end else if (i_cmd.finish) begin
            r_out_new     <= wrpm_pkg::IDX_OUT_W'(r_count[IDX_W-1:0]);
            r_out_partner <= r_pend_vld ? wrpm_pkg::IDX_OUT_W'(r_pend_idx) : '0;
            r_out_found   <= r_pend_vld;
            r_out_full    <= 1'b0;
            r_out_last    <= 1'b1;
        end else if (hit && r_pend_vld) begin
            r_out_new     <= wrpm_pkg::IDX_OUT_W'(r_count[IDX_W-1:0]);
            r_out_partner <= wrpm_pkg::IDX_OUT_W'(r_pend_idx);
            r_out_found   <= 1'b1;
            r_out_full    <= 1'b0;
            r_out_last    <= 1'b0;
        end
    end

    assign o_status.count_zero = (r_count == '0);
    assign o_status.full       = (r_count == CNT_W'(MAX_RECORDS));
    assign o_status.scan_end   = (CNT_W'(r_ptr) == (r_count - CNT_W'(1)));

    assign o_result_valid  = r_out_vld;
    assign o_new_index     = r_out_new;
    assign o_partner_index = r_out_partner;
    assign o_match_found   = r_out_found;
    assign o_table_full    = r_out_full;
    assign o_last          = r_out_last;

endmodule

`default_nettype wire

@@ src/windowed_record_pair_matcher.sv @@
// An insert scans the n stored records, reading them from the table RAM one per cycle, and
// its last result follows after the drain and finish states; an empty table skips the scan.
// The next item is taken only once the insert has finished and the block is idle again.
// A clear or a full-table reject is done without leaving idle; a reject result follows in the next cycle.
// Synchronous active-low reset empties the table and restores window 15 and count 2.
// Table contents are not cleared; only entries below the record count are ever read.
`default_nettype none

`include "windowed_record_pair_matcher_assert.svh"

module windowed_record_pair_matcher #(
    parameter int MAX_RECORDS    = wrpm_pkg::MAX_RECORDS_DEF,
    parameter int NUM_COVARIATES = wrpm_pkg::NUM_COV_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            i_cfg_we,
    input  wire logic [wrpm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [wrpm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                            i_mode,
    input  wire logic [wrpm_pkg::DATE_W-1:0]     i_record_date,
    input  wire logic [wrpm_pkg::KEY_W-1:0]      i_agent_key,
    input  wire logic [wrpm_pkg::KEY_W-1:0]      i_event_key,
    input  wire logic [wrpm_pkg::COV_W-1:0]      i_cov_a,
    input  wire logic [wrpm_pkg::COV_W-1:0]      i_cov_b,
    input  wire logic [wrpm_pkg::COV_W-1:0]      i_cov_c,
    input  wire logic [wrpm_pkg::COV_W-1:0]      i_cov_d,
    output logic                                 o_result_valid,
    output logic [wrpm_pkg::IDX_OUT_W-1:0]       o_new_index,
    output logic [wrpm_pkg::IDX_OUT_W-1:0]       o_partner_index,
    output logic                                 o_match_found,
    output logic                                 o_table_full,
    output logic                                 o_last
);

    wrpm_pkg::t_cmd    cmd;
    wrpm_pkg::t_status status;

    wrpm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_mode   (i_mode),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    wrpm_dp #(
        .MAX_RECORDS    (MAX_RECORDS),
        .NUM_COVARIATES (NUM_COVARIATES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_record_date   (i_record_date),
        .i_agent_key     (i_agent_key),
        .i_event_key     (i_event_key),
        .i_cov_a         (i_cov_a),
        .i_cov_b         (i_cov_b),
        .i_cov_c         (i_cov_c),
        .i_cov_d         (i_cov_d),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_result_valid  (o_result_valid),
        .o_new_index     (o_new_index),
        .o_partner_index (o_partner_index),
        .o_match_found   (o_match_found),
        .o_table_full    (o_table_full),
        .o_last          (o_last)
    );

    // An insert into a full table must give exactly one rejecting result next cycle.
    `WRPM_ASSERT_NEXT(a_full_reject, i_clk, i_rst_n, start && !busy && !i_mode && status.full, o_result_valid && o_table_full && o_last && !o_match_found, "full-table insert did not give a reject result")

    // A clear item empties the table at once.
    `WRPM_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, start && !busy && i_mode, status.count_zero && !busy, "clear item did not empty the table")

    // Finishing an insert always delivers the final result of that item.
    `WRPM_ASSERT_NEXT(a_finish_last, i_clk, i_rst_n, cmd.finish, o_result_valid && o_last && !o_table_full, "insert finished without a final result")

    // The block only becomes busy by accepting an item.
    `WRPM_ASSERT_NOW(a_busy_from_start, i_clk, i_rst_n, $rose(busy), $past(start), "busy rose without a start")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the windowed record pair matcher.
`default_nettype none

module testbench;

    localparam int MAX_RECORDS_DEF = wrpm_pkg::MAX_RECORDS_DEF;
    localparam int NUM_COV_DEF     = wrpm_pkg::NUM_COV_DEF;
    localparam int MAX_COV         = wrpm_pkg::MAX_COV;
    localparam int DATE_W          = wrpm_pkg::DATE_W;
    localparam int KEY_W           = wrpm_pkg::KEY_W;
    localparam int COV_W           = wrpm_pkg::COV_W;
    localparam int IDX_OUT_W       = wrpm_pkg::IDX_OUT_W;
    localparam int COVCNT_W        = wrpm_pkg::COVCNT_W;
    localparam int CFG_IDX_W       = wrpm_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W      = wrpm_pkg::CFG_DATA_W;

    localparam int TABLE_DEPTH = MAX_RECORDS_DEF;
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam longint RUN_LIMIT = 64'd4_000_000;

    typedef struct {
        logic              mode;
        logic [DATE_W-1:0] date;
        logic [KEY_W-1:0]  agent;
        logic [KEY_W-1:0]  evt;
        logic [COV_W-1:0]  cov [MAX_COV];
    } t_record;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] new_index;
        logic [IDX_OUT_W-1:0] partner_index;
        logic                 match_found;
        logic                 table_full;
        logic                 last_flag;
    } t_link;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_mode;
    logic [DATE_W-1:0]     i_record_date;
    logic [KEY_W-1:0]      i_agent_key;
    logic [KEY_W-1:0]      i_event_key;
    logic [COV_W-1:0]      i_cov_a;
    logic [COV_W-1:0]      i_cov_b;
    logic [COV_W-1:0]      i_cov_c;
    logic [COV_W-1:0]      i_cov_d;
    logic                  o_result_valid;
    logic [IDX_OUT_W-1:0]  o_new_index;
    logic [IDX_OUT_W-1:0]  o_partner_index;
    logic                  o_match_found;
    logic                  o_table_full;
    logic                  o_last;

    windowed_record_pair_matcher DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_mode         (i_mode),
        .i_record_date  (i_record_date),
        .i_agent_key    (i_agent_key),
        .i_event_key    (i_event_key),
        .i_cov_a        (i_cov_a),
        .i_cov_b        (i_cov_b),
        .i_cov_c        (i_cov_c),
        .i_cov_d        (i_cov_d),
        .o_result_valid (o_result_valid),
        .o_new_index    (o_new_index),
        .o_partner_index(o_partner_index),
        .o_match_found  (o_match_found),
        .o_table_full   (o_table_full),
        .o_last         (o_last)
    );

    // Shadow copy of the block's registers and record table.
    logic [DATE_W-1:0]   date_window;
    logic [COVCNT_W-1:0] cov_limit;
    int                  stored_count;
    logic [DATE_W-1:0]   tbl_date  [TABLE_DEPTH];
    logic [KEY_W-1:0]    tbl_agent [TABLE_DEPTH];
    logic [KEY_W-1:0]    tbl_event [TABLE_DEPTH];
    logic [COV_W-1:0]    tbl_cov   [TABLE_DEPTH][MAX_COV];

    t_link             link_q[$];
    logic [DATE_W-1:0] date_base;
    bit                sender_gaps;
    int                fault_count;
    int                items_sent;
    int                clears_sent;
    int                results_seen;
    int                partner_links;
    int                full_rejects;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic void add_link(input t_link l);
        link_q = {link_q, l};
    endfunction

    function automatic void predict_links(input t_record r);
        int  ncmp;
        int  hits[$];
        bit  cov_ok;
        logic [DATE_W-1:0] gap;
        if (r.mode == MODE_CLEAR) begin
            stored_count = 0;
            clears_sent++;
            return;
        end
        if (stored_count >= TABLE_DEPTH) begin
            add_link('{6'd0, 6'd0, 1'b0, 1'b1, 1'b1});
            return;
        end
        ncmp = (cov_limit > NUM_COV_DEF) ? NUM_COV_DEF : int'(cov_limit);
        for (int j = 0; j < stored_count; j++) begin
            gap = (r.date >= tbl_date[j]) ? r.date - tbl_date[j] : tbl_date[j] - r.date;
            if (tbl_agent[j] != r.agent && tbl_event[j] != r.evt && gap <= date_window) begin
                cov_ok = 1'b1;
                for (int k = 0; k < ncmp; k++) begin
                    if (tbl_cov[j][k] != r.cov[k]) cov_ok = 1'b0;
                end
                if (cov_ok) hits = {hits, j};
            end
        end
        if (hits.size() == 0) begin
            add_link('{IDX_OUT_W'(stored_count), 6'd0, 1'b0, 1'b0, 1'b1});
        end else begin
            foreach (hits[h]) begin
                add_link('{IDX_OUT_W'(stored_count), IDX_OUT_W'(hits[h]), 1'b1, 1'b0,
                           h == hits.size() - 1});
            end
        end
        tbl_date[stored_count]  = r.date;
        tbl_agent[stored_count] = r.agent;
        tbl_event[stored_count] = r.evt;
        for (int k = 0; k < MAX_COV; k++) tbl_cov[stored_count][k] = r.cov[k];
        stored_count++;
    endfunction

    function automatic t_record make_rec(input logic mode, input logic [DATE_W-1:0] date,
                                         input logic [KEY_W-1:0] agent,
                                         input logic [KEY_W-1:0] evt,
                                         input logic [COV_W-1:0] a, input logic [COV_W-1:0] b,
                                         input logic [COV_W-1:0] c, input logic [COV_W-1:0] d);
        t_record r;
        r.mode  = mode;
        r.date  = date;
        r.agent = agent;
        r.evt   = evt;
        r.cov[0] = a;
        r.cov[1] = b;
        r.cov[2] = c;
        r.cov[3] = d;
        return r;
    endfunction

    // Keys and covariates come mostly from tiny pools and dates from a narrow
    // band around the current base, so that partners are common.
    function automatic t_record rand_record();
        t_record r;
        int span;
        span = (date_window < 20) ? int'(date_window) + 4 : 40;
        r.mode = ($urandom_range(0, 99) < 4) ? MODE_CLEAR : MODE_INSERT;
        if ($urandom_range(0, 9) == 0) r.date = DATE_W'($urandom);
        else r.date = date_base + DATE_W'($urandom_range(0, span));
        r.agent = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5);
        r.evt   = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5);
        for (int k = 0; k < MAX_COV; k++) begin
            r.cov[k] = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 1);
        end
        return r;
    endfunction

    task automatic send_item(input t_record r);
        @(negedge i_clk);
        while (sender_gaps && $urandom_range(0, 99) < 13) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        i_mode        <= r.mode;
        i_record_date <= r.date;
        i_agent_key   <= r.agent;
        i_event_key   <= r.evt;
        i_cov_a       <= r.cov[0];
        i_cov_b       <= r.cov[1];
        i_cov_c       <= r.cov[2];
        i_cov_d       <= r.cov[3];
        start         <= 1'b1;
        do @(posedge i_clk); while (busy);
        predict_links(r);
        items_sent++;
    endtask

    // Holds the sender off until every predicted result has arrived and the
    // block has gone quiet; a clear leaves no result behind, hence the pause.
    task automatic drain_links();
        @(negedge i_clk);
        start <= 1'b0;
        while (link_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        while (busy) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            wrpm_pkg::CFG_DATE_WINDOW: date_window = data;
            wrpm_pkg::CFG_COV_COUNT:   cov_limit = data[COVCNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic test_reset_defaults();
        // Window 15 and two covariates straight out of reset.
        send_item(make_rec(MODE_INSERT, 16'd100, 32'd1, 32'd1, 32'd5, 32'd6, 32'd7, 32'd8));
        send_item(make_rec(MODE_INSERT, 16'd115, 32'd2, 32'd2, 32'd5, 32'd6, 32'd0, 32'd0));
        send_item(make_rec(MODE_INSERT, 16'd131, 32'd3, 32'd3, 32'd5, 32'd6, 32'd1, 32'd1));
        send_item(make_rec(MODE_INSERT, 16'd116, 32'd1, 32'd9, 32'd5, 32'd6, 32'd2, 32'd2));
        send_item(make_rec(MODE_INSERT, 16'd100, 32'd7, 32'd2, 32'd5, 32'd6, 32'd3, 32'd3));
        send_item(make_rec(MODE_INSERT, 16'd101, 32'd8, 32'd8, 32'd5, 32'd9, 32'd3, 32'd3));
        send_item(make_rec(MODE_INSERT, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
        send_item(make_rec(MODE_INSERT, 16'd14, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_rec(MODE_INSERT, 16'hFFFF, 32'hFFFF_FFFE, 32'h0000_0001,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_rec(MODE_CLEAR, DATE_W'($urandom), $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom));
        send_item(make_rec(MODE_INSERT, 16'd200, 32'd1, 32'd1, 32'd5, 32'd6, 32'd7, 32'd8));
        send_item(make_rec(MODE_INSERT, 16'd190, 32'd2, 32'd2, 32'd5, 32'd6, 32'd7, 32'd8));
    endtask

    task automatic test_register_extremes();
        drain_links();
        write_reg(wrpm_pkg::CFG_DATE_WINDOW, 16'd0);
        write_reg(wrpm_pkg::CFG_COV_COUNT, 16'd4);
        send_item(make_rec(MODE_CLEAR, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
        send_item(make_rec(MODE_INSERT, 16'd500, 32'd1, 32'd1, 32'd1, 32'd2, 32'd3, 32'd4));
        send_item(make_rec(MODE_INSERT, 16'd500, 32'd2, 32'd2, 32'd1, 32'd2, 32'd3, 32'd4));
        send_item(make_rec(MODE_INSERT, 16'd501, 32'd3, 32'd3, 32'd1, 32'd2, 32'd3, 32'd4));
        send_item(make_rec(MODE_INSERT, 16'd500, 32'd4, 32'd4, 32'd1, 32'd2, 32'd3, 32'd5));
        // A count field of zero with the upper bits of the data word set checks masking.
        drain_links();
        write_reg(wrpm_pkg::CFG_DATE_WINDOW, 16'hFFFF);
        write_reg(wrpm_pkg::CFG_COV_COUNT, 16'hFFF8);
        write_reg(CFG_SPARE_2, 16'h0000);
        write_reg(CFG_SPARE_3, 16'hFFFF);
        send_item(make_rec(MODE_INSERT, 16'd0, 32'd5, 32'd5, 32'd9, 32'd9, 32'd9, 32'd9));
        send_item(make_rec(MODE_INSERT, 16'hFFFF, 32'd6, 32'd6, 32'd8, 32'd8, 32'd8, 32'd8));
        // A count above the covariate number compares all four words.
        drain_links();
        write_reg(wrpm_pkg::CFG_COV_COUNT, 16'h0007);
        send_item(make_rec(MODE_INSERT, 16'd7, 32'd7, 32'd7, 32'd1, 32'd2, 32'd3, 32'd4));
        send_item(make_rec(MODE_INSERT, 16'd9, 32'd8, 32'd8, 32'd1, 32'd2, 32'd3, 32'd4));
    endtask

    task automatic test_table_full();
        t_record r;
        drain_links();
        write_reg(wrpm_pkg::CFG_DATE_WINDOW, 16'hFFFF);
        write_reg(wrpm_pkg::CFG_COV_COUNT, 16'd0);
        send_item(make_rec(MODE_CLEAR, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
        // Distinct keys and no compared covariates: every stored record is a
        // partner, so the last insert before the table fills gives 63 links.
        for (int i = 0; i < TABLE_DEPTH + 2; i++) begin
            r = rand_record();
            r.mode  = MODE_INSERT;
            r.agent = KEY_W'(i + 1);
            r.evt   = ~KEY_W'(i + 1);
            send_item(r);
        end
        send_item(make_rec(MODE_CLEAR, DATE_W'($urandom), $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom));
        send_item(make_rec(MODE_INSERT, 16'd3, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6));
    endtask

    task automatic test_random_traffic();
        logic [DATE_W-1:0]   windows [5] = '{16'd15, 16'd0, 16'd65535, 16'd7, 16'd300};
        logic [COVCNT_W-1:0] counts  [5] = '{3'd2, 3'd4, 3'd1, 3'd0, 3'd5};
        for (int p = 0; p < 5; p++) begin
            drain_links();
            write_reg(wrpm_pkg::CFG_DATE_WINDOW, windows[p]);
            write_reg(wrpm_pkg::CFG_COV_COUNT, {13'($urandom), counts[p]});
            sender_gaps = (p != 3);
            date_base = DATE_W'($urandom);
            send_item(make_rec(MODE_CLEAR, DATE_W'($urandom), $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom));
            for (int i = 0; i < 53; i++) begin
                if (p == 2 && i == 30) drain_links();
                if ($urandom_range(0, 19) == 0) date_base = DATE_W'($urandom);
                send_item(rand_record());
            end
        end
        sender_gaps = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_link got;
        t_link want;
        if (i_rst_n && o_result_valid) begin
            got = '{o_new_index, o_partner_index, o_match_found, o_table_full, o_last};
            results_seen++;
            if (o_match_found) partner_links++;
            if (o_table_full) full_rejects++;
            if (link_q.size() == 0) begin
                fault_count++;
                $display("%0t: unexpected result: expected none, got new=%0d partner=%0d",
                         $time, got.new_index, got.partner_index);
            end else begin
                want = link_q.pop_front();
                if (got != want) begin
                    fault_count++;
                    $display("%0t: expected new=%0d partner=%0d found=%0d full=%0d last=%0d",
                             $time, want.new_index, want.partner_index, want.match_found,
                             want.table_full, want.last_flag);
                    $display("%0t:   actual new=%0d partner=%0d found=%0d full=%0d last=%0d",
                             $time, got.new_index, got.partner_index, got.match_found,
                             got.table_full, got.last_flag);
                end
            end
        end
    end

    initial begin
        int waited;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        i_mode = MODE_INSERT;
        i_record_date = '0;
        i_agent_key = '0;
        i_event_key = '0;
        i_cov_a = '0;
        i_cov_b = '0;
        i_cov_c = '0;
        i_cov_d = '0;
        date_window = wrpm_pkg::WINDOW_RESET;
        cov_limit = wrpm_pkg::COVCNT_RESET;
        stored_count = 0;
        date_base = 16'd1000;
        sender_gaps = 1'b1;
        fault_count = 0;
        items_sent = 0;
        clears_sent = 0;
        results_seen = 0;
        partner_links = 0;
        full_rejects = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_table_full();
        test_random_traffic();

        @(negedge i_clk);
        start <= 1'b0;
        waited = 0;
        while (link_q.size() != 0 && waited < 10000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (70) @(negedge i_clk);
        if (link_q.size() != 0) begin
            fault_count += link_q.size();
            $display("%0t: %0d expected results never arrived", $time, link_q.size());
        end
        $display("Sent %0d items (%0d clears) over many window and covariate settings.",
                 items_sent, clears_sent);
        $display("Checked %0d results: %0d partner links, %0d table-full rejects.",
                 results_seen, partner_links, full_rejects);
        if (fault_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("%0t: run did not finish in time", $time);
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
